[hdl/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants of the Sobel edge magnitude block
// Holds the command and register codes, the queue sizing and the entry
// that the front part hands to the back part.
// ----------------------------------------------------------------------------
package sem_pkg;

	// Input item kinds, carried on s_tuser.
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Configuration register indexes.
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// Configuration field widths and reset values.
	localparam int CFG_DATA_W   = 12;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_W     = 12;
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;
	localparam int MIN_DIM      = 3;

	// Pixel and result widths.
	localparam int PIX_W     = 8;
	localparam int GRAD_W    = 11;
	localparam int MAG_LIMIT = 255;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_LW    = 3;

	// One classified item on its way to the back part.
	typedef struct packed {
		logic             is_pixel;
		logic             emit;
		logic             interior;
		logic             last;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] px;
	} sem_entry_t;

endpackage

[hdl/sem_front.sv]
// ----------------------------------------------------------------------------
// sem_front: input side of the Sobel edge magnitude block
// Accepts pixel and drain beats, tracks input and output raster positions,
// keeps the two line buffers and hands classified items to the queue.
// ----------------------------------------------------------------------------
module sem_front #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]        img_width,
	input  logic [sem_pkg::HEIGHT_W-1:0]          img_height,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [sem_pkg::PIX_W-1:0]             s_tdata,
	input  logic                                  s_tuser,
	input  logic [sem_pkg::QUEUE_LW-1:0]          q_level,
	output logic                                  push,
	output sem_pkg::sem_entry_t                   push_entry
);
	import sem_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH+1);
	localparam int PW = $clog2(MAX_WIDTH+2);
	localparam int RW = HEIGHT_W + 1;

	logic [CW-1:0]       in_col_q, out_col_q;
	logic [HEIGHT_W-1:0] in_row_q, out_row_q;
	logic [PW-1:0]       pending_q;

	logic                valid_s1, is_pixel_s1, emit_s1, interior_s1, last_s1;
	logic [CW-1:0]       col_s1;
	logic [PIX_W-1:0]    px_s1;
	logic [2*PIX_W-1:0]  rd_s1;

	logic [2*PIX_W-1:0]  line_mem [MAX_WIDTH];

	logic accept, is_pixel, pix_emit, emit, interior, last;
	logic in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;

	// Room check: the queue plus the item in stage one must leave a slot.
	assign s_tready = ({1'b0, q_level} + {{QUEUE_LW{1'b0}}, valid_s1})
		< (QUEUE_LW+1)'(QUEUE_DEPTH);
	assign accept   = s_tvalid && s_tready;
	assign is_pixel = (s_tuser == CMD_PIXEL);

	// A pixel releases a result once the lag of one row plus one pixel is full.
	assign pix_emit = pending_q > PW'(img_width);
	assign emit     = is_pixel ? pix_emit : (pending_q != '0);

	// Classify the output position that the next result belongs to.
	always_comb begin
		interior = (out_row_q != '0)
			&& ((RW'(out_row_q) + RW'(2)) <= RW'(img_height))
			&& (out_col_q != '0)
			&& (((WW+1)'(out_col_q) + (WW+1)'(2)) <= (WW+1)'(img_width));
		last = ((RW'(out_row_q) + RW'(1)) == RW'(img_height))
			&& ((WW'(out_col_q) + WW'(1)) == img_width);
	end

	// Raster wrap conditions.
	assign in_col_wrap  = (WW'(in_col_q) + WW'(1)) >= img_width;
	assign in_row_wrap  = (RW'(in_row_q) + RW'(1)) >= RW'(img_height);
	assign out_col_wrap = (WW'(out_col_q) + WW'(1)) >= img_width;
	assign out_row_wrap = (RW'(out_row_q) + RW'(1)) >= RW'(img_height);

	// Position counters and the count of positions still owed a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			pending_q   <= '0;
			valid_s1    <= 1'b0;
			is_pixel_s1 <= 1'b0;
			emit_s1     <= 1'b0;
			interior_s1 <= 1'b0;
			last_s1     <= 1'b0;
		end else if (restart) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept && (is_pixel || emit);
			if (accept) begin
				is_pixel_s1 <= is_pixel;
				emit_s1     <= emit;
				interior_s1 <= is_pixel && interior;
				last_s1     <= last;
				if (is_pixel) begin
					if (in_col_wrap) begin
						in_col_q <= '0;
						in_row_q <= in_row_wrap ? '0 : in_row_q + 1'b1;
					end else begin
						in_col_q <= in_col_q + 1'b1;
					end
				end
				if (emit) begin
					if (out_col_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_wrap ? '0 : out_row_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end
				if (is_pixel && !pix_emit) begin
					pending_q <= pending_q + 1'b1;
				end else if (!is_pixel && emit) begin
					pending_q <= pending_q - 1'b1;
				end
			end
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= in_col_q;
			px_s1  <= s_tdata;
		end
	end

	// Line memory: upper row in the high byte, middle row in the low byte.
	// Read at accept, rewritten in the following cycle with the row shifted up.
	always_ff @(posedge clk) begin
		if (accept && is_pixel) begin
			rd_s1 <= line_mem[in_col_q];
		end
		if (valid_s1 && is_pixel_s1) begin
			line_mem[col_s1] <= {rd_s1[PIX_W-1:0], px_s1};
		end
	end

	// Hand the classified item to the queue.
	assign push = valid_s1;
	always_comb begin
		push_entry.is_pixel = is_pixel_s1;
		push_entry.emit     = emit_s1;
		push_entry.interior = interior_s1;
		push_entry.last     = last_s1;
		push_entry.top      = rd_s1[2*PIX_W-1:PIX_W];
		push_entry.mid      = rd_s1[PIX_W-1:0];
		push_entry.px       = px_s1;
	end

endmodule

[hdl/sem_queue.sv]
// ----------------------------------------------------------------------------
// sem_queue: short queue between front and back
// A small register queue that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module sem_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic                         push,
	input  sem_pkg::sem_entry_t          push_entry,
	input  logic                         pop,
	output logic                         q_valid,
	output sem_pkg::sem_entry_t          head,
	output logic [sem_pkg::QUEUE_LW-1:0] level
);
	import sem_pkg::*;

	sem_entry_t          entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_LW-1:0] level_q;

	assign q_valid = (level_q != '0);
	assign head    = entries_q[rd_ptr_q];
	assign level   = level_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else if (restart) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[hdl/sem_back.sv]
// ----------------------------------------------------------------------------
// sem_back: output side of the Sobel edge magnitude block
// Slides the 3x3 window, forms both gradients, then the saturated L1
// magnitude, or zero outside the interior, in the output register.
// ----------------------------------------------------------------------------
module sem_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      restart,
	input  logic                      q_valid,
	input  sem_pkg::sem_entry_t       head,
	output logic                      pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [sem_pkg::PIX_W-1:0] m_tdata,
	output logic                      m_tlast
);
	import sem_pkg::*;

	logic [PIX_W-1:0]  win_q [9];
	logic [PIX_W-1:0]  nw [9];
	logic [GRAD_W-1:0] gx, gy;

	logic              valid_s1, interior_s1, last_s1;
	logic [GRAD_W-1:0] gx_s1, gy_s1;
	logic              valid_s2, last_s2;
	logic [PIX_W-1:0]  mag_s2;

	logic              out_free, b1_free;
	logic [GRAD_W-1:0] abs_x, abs_y, sum;

	assign out_free = !valid_s2 || m_tready;
	assign b1_free  = !valid_s1 || out_free;
	assign pop      = q_valid && b1_free;

	// Window after shifting in the new column: top, middle, bottom rows.
	always_comb begin
		nw[0] = win_q[1]; nw[1] = win_q[2]; nw[2] = head.top;
		nw[3] = win_q[4]; nw[4] = win_q[5]; nw[5] = head.mid;
		nw[6] = win_q[7]; nw[7] = win_q[8]; nw[8] = head.px;
	end

	// Gradients in two's complement; the range fits eleven bits.
	always_comb begin
		gx = GRAD_W'(nw[0]) + (GRAD_W'(nw[3]) << 1) + GRAD_W'(nw[6])
			- GRAD_W'(nw[2]) - (GRAD_W'(nw[5]) << 1) - GRAD_W'(nw[8]);
		gy = GRAD_W'(nw[0]) + (GRAD_W'(nw[1]) << 1) + GRAD_W'(nw[2])
			- GRAD_W'(nw[6]) - (GRAD_W'(nw[7]) << 1) - GRAD_W'(nw[8]);
	end

	// Absolute values and their sum.
	always_comb begin
		abs_x = gx_s1[GRAD_W-1] ? (~gx_s1 + 1'b1) : gx_s1;
		abs_y = gy_s1[GRAD_W-1] ? (~gy_s1 + 1'b1) : gy_s1;
		sum   = abs_x + abs_y;
	end

	// Control and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (restart) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			if (b1_free) begin
				valid_s1 <= pop && head.emit;
			end
			if (pop && head.is_pixel) begin
				for (int i = 0; i < 9; i++) begin
					win_q[i] <= nw[i];
				end
			end
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (pop) begin
			gx_s1       <= gx;
			gy_s1       <= gy;
			interior_s1 <= head.interior;
			last_s1     <= head.last;
		end
		if (out_free && valid_s1) begin
			last_s2 <= last_s1;
			if (!interior_s1) begin
				mag_s2 <= '0;
			end else if (sum > GRAD_W'(MAG_LIMIT)) begin
				mag_s2 <= PIX_W'(MAG_LIMIT);
			end else begin
				mag_s2 <= sum[PIX_W-1:0];
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = mag_s2;
	assign m_tlast  = last_s2;

endmodule

[hdl/sobel_edge_magnitude_top.sv]
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_top: streaming 3x3 Sobel edge detector, L1 magnitude
// Takes one gray pixel or drain beat per clock while s_tready is high and
// gives one result beat per released position, |gx|+|gy| saturated at 255,
// with zero on the frame border and m_tlast on the last position of the
// frame. A result is released one row plus one pixel after its pixel; drain
// beats release the rest. The sustained rate is one beat per clock on both
// sides while m_tready is high, set by the single line memory (MAX_WIDTH x
// 16 bits, one read and one write each cycle). No clearing pass runs after
// reset. A configuration write restarts the frame; the user makes it only
// while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_top #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port.
	input  logic                           cfg_wen,
	input  logic                           cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sem_pkg::PIX_W-1:0]      s_tdata,   // [7:0] pixel
	input  logic                           s_tuser,   // [0] cmd
	// Output stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sem_pkg::PIX_W-1:0]      m_tdata,   // [7:0] magnitude
	output logic                           m_tlast    // frame_end
);
	import sem_pkg::*;

	localparam int WW      = $clog2(MAX_WIDTH+1);
	localparam int RESET_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

	logic [WW-1:0]          width_q;
	logic [HEIGHT_W-1:0]    height_q;
	logic [WIDTH_REG_W-1:0] wr_width;

	logic                   push, pop, q_valid;
	sem_entry_t             push_entry, head;
	logic [QUEUE_LW-1:0]    q_level;

	assign wr_width = cfg_data[WIDTH_REG_W-1:0];

	// Frame size registers, held clamped to their legal ranges.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(RESET_W);
			height_q <= HEIGHT_W'(HEIGHT_RESET);
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					if (wr_width < WIDTH_REG_W'(MIN_DIM)) begin
						width_q <= WW'(MIN_DIM);
					end else if (13'(wr_width) > 13'(MAX_WIDTH)) begin
						width_q <= WW'(MAX_WIDTH);
					end else begin
						width_q <= WW'(wr_width);
					end
				end
				REG_IMAGE_HEIGHT: begin
					if (cfg_data < HEIGHT_W'(MIN_DIM)) begin
						height_q <= HEIGHT_W'(MIN_DIM);
					end else begin
						height_q <= cfg_data;
					end
				end
				default: begin
					width_q <= width_q;
				end
			endcase
		end
	end

	sem_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_wen),
		.img_width  (width_q),
		.img_height (height_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_level    (q_level),
		.push       (push),
		.push_entry (push_entry)
	);

	sem_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_wen),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.q_valid    (q_valid),
		.head       (head),
		.level      (q_level)
	);

	sem_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_wen),
		.q_valid  (q_valid),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[hdl/sem_checker.sv]
// ----------------------------------------------------------------------------
// sem_checker: port-level checks for the Sobel edge magnitude block
// Watches the top-level ports and flags handshake and restart slips.
// ----------------------------------------------------------------------------
module sem_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_wen,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [sem_pkg::PIX_W-1:0] s_tdata,
	input logic                      s_tuser,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [sem_pkg::PIX_W-1:0] m_tdata,
	input logic                      m_tlast
);
	import sem_pkg::*;

	// A stalled input beat holds its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input beat changed while stalled");

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	// A configuration write drops any result in flight.
	a_cfg_flush: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |=> !m_tvalid)
		else $error("result still offered after a configuration write");

	// After a configuration write the input side is free again.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |=> s_tready)
		else $error("input not ready after a configuration write");

endmodule

bind sobel_edge_magnitude_top sem_checker u_sem_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_wen  (cfg_wen),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sobel_edge_magnitude_top
// Streams gray pixel and drain beats into the edge detector and predicts
// every result beat: the bench keeps its own line buffers, 3x3 window and
// frame counters. Each result beat is checked against the oldest prediction.
// The run starts with a short directed frame. Random phases follow, each
// with its own frame size, then clamped, widest and tallest frame settings.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sem_pkg::*;

	localparam int MAX_WIDTH     = 1024;
	localparam int HEIGHT_LIMIT  = 4095;
	localparam int CENTER_WEIGHT = 2;
	localparam int RANDOM_BEATS  = 640;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_BOUND   = 20000;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int STALL_AT      = 500;
	localparam int STALL_LEN     = 300;

	typedef struct packed {
		logic             cmd;
		logic [PIX_W-1:0] px;
	} pixel_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0] mag;
		logic             frame_end;
	} edge_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wen   = 1'b0;
	logic                  cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata   = '0;   // [7:0] pixel
	logic                  s_tuser   = CMD_PIXEL;   // [0] cmd
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [PIX_W-1:0]      m_tdata;   // [7:0] magnitude
	logic                  m_tlast;

	pixel_beat_t  beat_backlog[$];
	edge_result_t edge_results_due[$];

	int unsigned queued_beats = 0;
	int unsigned beats_in     = 0;
	int          fail_count   = 0;
	int          cycle_count  = 0;
	int          send_gap_pct = 0;
	int          recv_gap_pct = 0;
	int          stall_left   = 0;
	logic        stall_done   = 1'b0;

	// Shadow state of the edge detector.
	int unsigned      width_reg;
	int unsigned      height_reg;
	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem[MAX_WIDTH];
	logic [PIX_W-1:0] win[9];
	int unsigned      in_col, in_row, out_col, out_row;

	sobel_edge_magnitude_top #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Out-of-range sizes are clamped when used.
	function automatic int unsigned eff_dim(input int unsigned raw, input int unsigned hi);
		if (raw < MIN_DIM) return MIN_DIM;
		if (raw > hi) return hi;
		return raw;
	endfunction

	function automatic void step_position(inout int unsigned col, inout int unsigned row,
			input int unsigned w, input int unsigned h);
		if (col + 1 >= w) begin
			col = 0;
			row = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			col = col + 1;
		end
	endfunction

	// Releases the result of the next output position.
	function automatic void release_result(input logic use_win, input int unsigned w,
			input int unsigned h);
		int           gx;
		int           gy;
		int           sum;
		logic         interior;
		edge_result_t res;
		interior = out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w;
		gx = int'(win[0]) + CENTER_WEIGHT * int'(win[3]) + int'(win[6])
			- int'(win[2]) - CENTER_WEIGHT * int'(win[5]) - int'(win[8]);
		gy = int'(win[0]) + CENTER_WEIGHT * int'(win[1]) + int'(win[2])
			- int'(win[6]) - CENTER_WEIGHT * int'(win[7]) - int'(win[8]);
		sum = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
		if (sum > MAG_LIMIT) sum = MAG_LIMIT;
		res.mag       = (use_win && interior) ? PIX_W'(sum) : '0;
		res.frame_end = (out_row + 1 == h) && (out_col + 1 == w);
		edge_results_due.push_back(res);
		step_position(out_col, out_row, w, h);
	endfunction

	// Advances the shadow state by one accepted input beat.
	function automatic void sobel_accept_beat(input logic cmd, input logic [PIX_W-1:0] px);
		int unsigned      w;
		int unsigned      h;
		int unsigned      pend;
		int unsigned      c;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		w = eff_dim(width_reg, MAX_WIDTH);
		h = eff_dim(height_reg, HEIGHT_LIMIT);
		pend = ((in_row * w + in_col) + w * h - (out_row * w + out_col)) % (w * h);
		if (cmd == CMD_DRAIN) begin
			if (pend != 0) release_result(1'b0, w, h);
		end else begin
			c = in_col;
			top = upper_mem[c];
			mid = middle_mem[c];
			upper_mem[c] = mid;
			middle_mem[c] = px;
			win[0] = win[1]; win[1] = win[2]; win[2] = top;
			win[3] = win[4]; win[4] = win[5]; win[5] = mid;
			win[6] = win[7]; win[7] = win[8]; win[8] = px;
			step_position(in_col, in_row, w, h);
			if (pend + 1 > w + 1) release_result(1'b1, w, h);
		end
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 5))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			default: begin
				return PIX_W'($urandom_range(0, 255));
			end
		endcase
	endfunction

	function automatic void push_beat(input logic cmd, input logic [PIX_W-1:0] px);
		pixel_beat_t b;
		b.cmd = cmd;
		b.px  = px;
		beat_backlog.push_back(b);
		queued_beats++;
	endfunction

	// Register write; any write restarts the frame on both sides.
	task automatic write_reg(input logic idx, input int unsigned val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_IMAGE_WIDTH) width_reg = val & 'h7FF;
		else height_reg = val & 'hFFF;
		foreach (win[k]) win[k] = '0;
		in_col  = 0;
		in_row  = 0;
		out_col = 0;
		out_row = 0;
	endtask

	// Waits until every queued beat is taken and every due result is back.
	task automatic wait_drained();
		int n;
		n = 0;
		while ((beat_backlog.size() != 0 || s_tvalid || edge_results_due.size() != 0)
				&& n < DRAIN_BOUND) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Input driver: predicts each accepted beat, then offers the next one.
	always @(posedge clk) begin : feed_proc
		pixel_beat_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sobel_accept_beat(s_tuser, s_tdata);
				beats_in <= beats_in + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (beat_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					nxt = beat_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.px;
					s_tuser  <= nxt.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure and one long hold-off.
	always @(posedge clk) begin : collect_proc
		edge_result_t due;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (edge_results_due.size() == 0) begin
					$error("result beat with none due: magnitude %0d frame_end %0b",
						m_tdata, m_tlast);
					fail_count++;
				end else begin
					due = edge_results_due.pop_front();
					if (m_tdata !== due.mag) begin
						$error("magnitude: expected %0d, got %0d", due.mag, m_tdata);
						fail_count++;
					end
					if (m_tlast !== due.frame_end) begin
						$error("frame_end: expected %0b, got %0b", due.frame_end, m_tlast);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				m_tready   <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!stall_done && beats_in >= STALL_AT) begin
				m_tready   <= 1'b0;
				stall_left <= STALL_LEN;
				stall_done <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sobel_edge_magnitude_top verification failed");
			$finish;
		end
	end

	initial begin : stim_proc
		int unsigned w_raw;
		int unsigned h_raw;
		int unsigned w_eff;
		int unsigned h_eff;
		int unsigned npix;
		int unsigned ndrain;
		int unsigned rand_start;
		int          sel;

		width_reg  = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		foreach (upper_mem[k]) upper_mem[k] = '0;
		foreach (middle_mem[k]) middle_mem[k] = '0;
		foreach (win[k]) win[k] = '0;
		in_col  = 0;
		in_row  = 0;
		out_col = 0;
		out_row = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		send_gap_pct = 36;
		recv_gap_pct = 55;

		// Smallest frame: bright top row over a dark rest saturates the center,
		// then a drain run ends the frame and one more drain finds nothing.
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, 3);
		repeat (3) push_beat(CMD_PIXEL, 8'd255);
		repeat (6) push_beat(CMD_PIXEL, 8'd0);
		repeat (4) push_beat(CMD_DRAIN, rand_pixel());
		push_beat(CMD_DRAIN, 8'hFF);
		// Drain in mid frame, then pixels that rebuild the lag.
		push_beat(CMD_PIXEL, 8'd0);
		push_beat(CMD_PIXEL, 8'd255);
		push_beat(CMD_PIXEL, 8'd128);
		push_beat(CMD_DRAIN, 8'h00);
		push_beat(CMD_PIXEL, 8'd77);
		push_beat(CMD_PIXEL, 8'd200);
		wait_drained();

		// Random phases, mostly small frames.
		rand_start = queued_beats;
		while (queued_beats - rand_start < RANDOM_BEATS) begin
			if (queued_beats - rand_start < RANDOM_BEATS / 3) begin
				send_gap_pct = 36;
				recv_gap_pct = 55;
			end else if (queued_beats - rand_start < 2 * RANDOM_BEATS / 3) begin
				send_gap_pct = 55;
				recv_gap_pct = 36;
			end else begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end

			sel = $urandom_range(0, 9);
			if (sel < 7) w_raw = $urandom_range(3, 12);
			else if (sel < 9) w_raw = $urandom_range(13, 48);
			else w_raw = $urandom_range(0, 2);
			// Bit 11 lies beyond the width register and must be ignored.
			w_raw = w_raw | ($urandom_range(0, 1) << 11);
			sel = $urandom_range(0, 9);
			if (sel < 7) h_raw = $urandom_range(3, 8);
			else if (sel == 7) h_raw = $urandom_range(0, 2);
			else if (sel == 8) h_raw = HEIGHT_LIMIT;
			else h_raw = $urandom_range(9, HEIGHT_LIMIT);

			if ($urandom_range(0, 1) == 0) begin
				write_reg(REG_IMAGE_WIDTH, w_raw);
				write_reg(REG_IMAGE_HEIGHT, h_raw);
			end else begin
				write_reg(REG_IMAGE_HEIGHT, h_raw);
				write_reg(REG_IMAGE_WIDTH, w_raw);
			end
			w_eff = eff_dim(w_raw & 'h7FF, MAX_WIDTH);
			h_eff = eff_dim(h_raw, HEIGHT_LIMIT);

			// Whole frames back to back, sometimes cut short.
			npix = $urandom_range(1, 3) * w_eff * h_eff;
			if (npix > 240) npix = $urandom_range(w_eff + 2, 240);
			if ($urandom_range(0, 4) == 0) npix = $urandom_range(1, npix);
			for (int unsigned i = 0; i < npix; i++) begin
				if ($urandom_range(0, 49) == 0) push_beat(CMD_DRAIN, rand_pixel());
				push_beat(CMD_PIXEL, rand_pixel());
			end
			// Usually flush the tail; sometimes leave it for the next write to drop.
			if ($urandom_range(0, 5) == 0) ndrain = $urandom_range(0, w_eff);
			else ndrain = w_eff + 1 + $urandom_range(0, 2);
			repeat (ndrain) push_beat(CMD_DRAIN, rand_pixel());
			wait_drained();
		end

		send_gap_pct = 0;
		recv_gap_pct = 0;

		// Width above the limit clamps to the widest row; the first results
		// come out just past one full row, and the rest of the tail is left
		// for the next write to drop.
		write_reg(REG_IMAGE_WIDTH, 2047);
		write_reg(REG_IMAGE_HEIGHT, 3);
		repeat (1030) push_beat(CMD_PIXEL, rand_pixel());
		repeat (4) push_beat(CMD_DRAIN, rand_pixel());
		wait_drained();

		// Widest and tallest legal frame, a few pixels only.
		write_reg(REG_IMAGE_WIDTH, MAX_WIDTH);
		write_reg(REG_IMAGE_HEIGHT, HEIGHT_LIMIT);
		repeat (10) push_beat(CMD_PIXEL, rand_pixel());
		repeat (11) push_beat(CMD_DRAIN, rand_pixel());
		wait_drained();

		// Zero in both registers clamps to the smallest frame.
		write_reg(REG_IMAGE_WIDTH, 'h800);
		write_reg(REG_IMAGE_HEIGHT, 0);
		repeat (9) push_beat(CMD_PIXEL, rand_pixel());
		repeat (4) push_beat(CMD_DRAIN, rand_pixel());
		wait_drained();

		if (edge_results_due.size() != 0) begin
			$error("%0d expected results never arrived", edge_results_due.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("sobel_edge_magnitude_top verification clean");
		end else begin
			$display("sobel_edge_magnitude_top verification failed");
		end
		$finish;
	end

endmodule

[sobel_edge_magnitude_top.f]
hdl/sem_pkg.sv
hdl/sem_front.sv
hdl/sem_queue.sv
hdl/sem_back.sv
hdl/sobel_edge_magnitude_top.sv
hdl/sem_checker.sv
bench/testbench.sv
